// ----- rtl/core/ffba_pkg.sv -----
`timescale 1ns / 1ps
package ffba_pkg;
    localparam int ARENA_BYTES   = 256 * 1024;
    localparam int HEADER_BYTES  = 16;
    localparam int GRANULE_BYTES = 16;
    localparam int GRAN_SHIFT    = $clog2(GRANULE_BYTES);
    localparam int BLOCKS        = ARENA_BYTES / GRANULE_BYTES;
    localparam int IDX_W         = $clog2(BLOCKS);
    localparam int HDR_GRANULES  = HEADER_BYTES / GRANULE_BYTES;
    localparam int REQ_W         = 24;
    localparam int ADDR_W        = 18;
    localparam int NEED_W        = REQ_W - GRAN_SHIFT + 1;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef struct packed {
        logic [IDX_W-1:0] size;
        logic             free;
        logic             has_next;
        logic [IDX_W-1:0] next;
    } hdr_t;

    localparam logic [IDX_W-1:0] FIRST_SIZE = IDX_W'(BLOCKS - HDR_GRANULES);
endpackage

// ----- rtl/core/ffba_hdr_ram.sv -----
`timescale 1ns / 1ps
module ffba_hdr_ram
    import ffba_pkg::*;
(
    input  logic             aclk,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output hdr_t             rd_data,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  hdr_t             wr_data
);
    hdr_t mem [BLOCKS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// ----- rtl/core/first_fit_block_allocator.sv -----
`timescale 1ns / 1ps
// Allocate: a zero request is answered from ST_IDLE, else ST_A_CHK walks the headers, with
// ST_A_SPLIT after it when a block is split. Release: an address below the header offset is
// answered from ST_IDLE, else ST_R_CHK walks, and ST_R_SUCC/ST_R_PREV free and merge.
// The walk reads one header per cycle from the header memory.
// One item is in work at a time; the result register frees the input side once taken.
// Reset (aresetn low, synchronous) clears control; ST_INIT then writes the first header.
module first_fit_block_allocator
    import ffba_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // request_size[23:0], release_address[41:24], zero pad
    input  logic [0:0]  s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // granted_address[17:0], zero pad
    output logic [0:0]  m_tuser    // success
);
    typedef enum logic [2:0] {
        ST_INIT, ST_IDLE, ST_A_CHK, ST_A_SPLIT, ST_R_CHK, ST_R_SUCC, ST_R_PREV
    } state_t;

    state_t            state_reg;
    logic [NEED_W-1:0] need_reg;
    logic [IDX_W-1:0]  cur_reg, tgt_reg, prev_reg, nb_reg;
    logic              aligned_reg, has_prev_reg;
    hdr_t              prev_hdr_reg, tnew_reg;
    logic              m_valid_reg, success_reg;
    logic [ADDR_W-1:0] grant_reg;

    hdr_t              h, wr_data, tnew_c;
    logic              rd_en, wr_en;
    logic [IDX_W-1:0]  rd_addr, wr_addr, nb_c;
    logic              fits, split, found, go_on;
    logic              in_beat;
    logic [REQ_W:0]    req_round;
    logic [ADDR_W-1:0] rel_c, rel_off;

    ffba_hdr_ram u_ram (
        .aclk(aclk), .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(h),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
    );

    assign s_tready  = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign in_beat   = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(24 - ADDR_W){1'b0}}, grant_reg};
    assign m_tuser   = success_reg;
    assign req_round = {1'b0, s_tdata[REQ_W-1:0]} + (REQ_W + 1)'(GRANULE_BYTES - 1);
    assign rel_c     = s_tdata[24 +: ADDR_W];
    assign rel_off   = rel_c - ADDR_W'(HEADER_BYTES);

    assign fits  = h.free && ({{(NEED_W - IDX_W){1'b0}}, h.size} >= need_reg);
    assign split = {{(NEED_W - IDX_W){1'b0}}, h.size} >= need_reg + NEED_W'(HDR_GRANULES + 1);
    assign nb_c  = cur_reg + IDX_W'(HDR_GRANULES) + need_reg[IDX_W-1:0];
    assign found = (cur_reg == tgt_reg) && aligned_reg;
    assign go_on = h.has_next && !(h.next > tgt_reg);

    always_comb begin
        tnew_c = h.free ? '{size: tnew_reg.size + IDX_W'(HDR_GRANULES) + h.size, free: 1'b1,
                            has_next: h.has_next, next: h.next} : tnew_reg;
        rd_en   = 1'b0;
        rd_addr = h.next;
        wr_en   = 1'b0;
        wr_addr = cur_reg;
        wr_data = '{size: h.size, free: 1'b0, has_next: h.has_next, next: h.next};
        case (state_reg)
            ST_INIT: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = '{size: FIRST_SIZE, free: 1'b1, has_next: 1'b0, next: '0};
            end
            ST_IDLE: begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            ST_A_CHK: begin
                if (fits && split) begin
                    wr_en   = 1'b1;
                    wr_addr = nb_c;
                    wr_data = '{size: h.size - need_reg[IDX_W-1:0] - IDX_W'(HDR_GRANULES),
                                free: 1'b1, has_next: h.has_next, next: h.next};
                end else if (fits) begin
                    wr_en = 1'b1;
                end else begin
                    rd_en = h.has_next;
                end
            end
            ST_A_SPLIT: begin
                wr_en   = 1'b1;
                wr_data = '{size: need_reg[IDX_W-1:0], free: 1'b0, has_next: 1'b1,
                            next: nb_reg};
            end
            ST_R_CHK: begin
                if (found) begin
                    if (!h.free && h.has_next) begin
                        rd_en = 1'b1;
                    end else if (!h.free) begin
                        wr_en   = 1'b1;
                        wr_data = '{size: h.size, free: 1'b1, has_next: 1'b0, next: h.next};
                    end
                end else begin
                    rd_en = go_on;
                end
            end
            ST_R_SUCC: begin
                wr_en   = 1'b1;
                wr_data = tnew_c;
            end
            ST_R_PREV: begin
                wr_en   = has_prev_reg && prev_hdr_reg.free;
                wr_addr = prev_reg;
                wr_data = '{size: prev_hdr_reg.size + IDX_W'(HDR_GRANULES) + tnew_reg.size,
                            free: 1'b1, has_next: tnew_reg.has_next, next: tnew_reg.next};
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_INIT: begin
                    state_reg <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (in_beat) begin
                        cur_reg      <= '0;
                        has_prev_reg <= 1'b0;
                        need_reg     <= req_round[REQ_W:GRAN_SHIFT];
                        tgt_reg      <= rel_off[ADDR_W-1:GRAN_SHIFT];
                        aligned_reg  <= (rel_c[GRAN_SHIFT-1:0] == '0);
                        grant_reg    <= '0;
                        success_reg  <= 1'b0;
                        if (s_tuser[0] == OP_ALLOC) begin
                            if (s_tdata[REQ_W-1:0] == '0) begin
                                m_valid_reg <= 1'b1;
                            end else begin
                                state_reg <= ST_A_CHK;
                            end
                        end else if (rel_c < ADDR_W'(HEADER_BYTES)) begin
                            m_valid_reg <= 1'b1;
                        end else begin
                            state_reg <= ST_R_CHK;
                        end
                    end
                end
                ST_A_CHK: begin
                    if (fits) begin
                        grant_reg <= ADDR_W'({cur_reg, {GRAN_SHIFT{1'b0}}}) +
                                     ADDR_W'(HEADER_BYTES);
                        success_reg <= 1'b1;
                        nb_reg      <= nb_c;
                        if (split) begin
                            state_reg <= ST_A_SPLIT;
                        end else begin
                            m_valid_reg <= 1'b1;
                            state_reg   <= ST_IDLE;
                        end
                    end else if (h.has_next) begin
                        cur_reg <= h.next;
                    end else begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                ST_A_SPLIT: begin
                    m_valid_reg <= 1'b1;
                    state_reg   <= ST_IDLE;
                end
                ST_R_CHK: begin
                    if (found) begin
                        tnew_reg <= '{size: h.size, free: 1'b1, has_next: h.has_next,
                                      next: h.next};
                        if (h.free) begin
                            m_valid_reg <= 1'b1;
                            state_reg   <= ST_IDLE;
                        end else if (h.has_next) begin
                            state_reg <= ST_R_SUCC;
                        end else begin
                            state_reg <= ST_R_PREV;
                        end
                    end else if (go_on) begin
                        prev_reg     <= cur_reg;
                        prev_hdr_reg <= h;
                        has_prev_reg <= 1'b1;
                        cur_reg      <= h.next;
                    end else begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                ST_R_SUCC: begin
                    tnew_reg  <= tnew_c;
                    state_reg <= ST_R_PREV;
                end
                ST_R_PREV: begin
                    success_reg <= 1'b1;
                    m_valid_reg <= 1'b1;
                    state_reg   <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !wr_en)
        else $error("header write while idle");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !success_reg) |-> (grant_reg == '0))
        else $error("failed beat carries an address");

    assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat |=> (m_valid_reg || (state_reg != ST_IDLE)))
        else $error("accepted beat left no work and no result");
endmodule

// ----- tb/sv/first_fit_block_allocator_tb.sv -----
`timescale 1ns / 1ps
module first_fit_block_allocator_tb
    import ffba_pkg::*;
;
    localparam int SLOTS      = ARENA_BYTES / GRANULE_BYTES;
    localparam int CYCLE_LIMIT = 4000000;

    typedef struct {
        logic [17:0] granted;
        logic        ok;
    } grant_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // request_size[23:0], release_address[41:24], zero pad
    logic [0:0]  s_tuser;   // op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;   // granted_address[17:0], zero pad
    logic [0:0]  m_tuser;   // success

    first_fit_block_allocator dut (.*);

    // shadow copy of the block chain, indexed by header offset / granule
    int unsigned hdr_size [SLOTS];
    int unsigned hdr_next [SLOTS];
    bit          hdr_link [SLOTS];
    bit          hdr_free [SLOTS];

    grant_t      grants_due[$];
    logic [17:0] live_blocks[$];
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_seq;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          mismatches;
    int          checked;
    int          beats_sent;
    int          cycles = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void chain_reset();
        hdr_size[0] = ARENA_BYTES - HEADER_BYTES;
        hdr_free[0] = 1'b1;
        hdr_link[0] = 1'b0;
        hdr_next[0] = 0;
    endfunction

    function automatic int unsigned chain_alloc(int unsigned req);
        int unsigned need;
        int unsigned b;
        int unsigned nb;
        if (req == 0) return 0;
        need = ((req + GRANULE_BYTES - 1) / GRANULE_BYTES) * GRANULE_BYTES;
        b = 0;
        forever begin
            if (hdr_free[b/16] && hdr_size[b/16] >= need) begin
                if (hdr_size[b/16] >= need + HEADER_BYTES + GRANULE_BYTES) begin
                    nb = b + HEADER_BYTES + need;
                    hdr_size[nb/16] = hdr_size[b/16] - need - HEADER_BYTES;
                    hdr_free[nb/16] = 1'b1;
                    hdr_next[nb/16] = hdr_next[b/16];
                    hdr_link[nb/16] = hdr_link[b/16];
                    hdr_size[b/16]  = need;
                    hdr_next[b/16]  = nb;
                    hdr_link[b/16]  = 1'b1;
                end
                hdr_free[b/16] = 1'b0;
                return b + HEADER_BYTES;
            end
            if (!hdr_link[b/16]) return 0;
            b = hdr_next[b/16];
        end
    endfunction

    function automatic bit chain_release(int unsigned addr);
        int unsigned target;
        int unsigned b;
        int unsigned prev;
        int unsigned s;
        bit has_prev;
        prev = 0;
        has_prev = 1'b0;
        if (addr < HEADER_BYTES) return 1'b0;
        target = addr - HEADER_BYTES;
        b = 0;
        while (b != target) begin
            if (!hdr_link[b/16] || hdr_next[b/16] > target) return 1'b0;
            prev = b;
            has_prev = 1'b1;
            b = hdr_next[b/16];
        end
        if (hdr_free[b/16]) return 1'b0;
        hdr_free[b/16] = 1'b1;
        if (hdr_link[b/16] && hdr_free[hdr_next[b/16]/16]) begin
            s = hdr_next[b/16];
            hdr_size[b/16] += HEADER_BYTES + hdr_size[s/16];
            hdr_next[b/16] = hdr_next[s/16];
            hdr_link[b/16] = hdr_link[s/16];
        end
        if (has_prev && hdr_free[prev/16]) begin
            hdr_size[prev/16] += HEADER_BYTES + hdr_size[b/16];
            hdr_next[prev/16] = hdr_next[b/16];
            hdr_link[prev/16] = hdr_link[b/16];
        end
        return 1'b1;
    endfunction

    function automatic grant_t chain_step(bit op, logic [23:0] req, logic [17:0] rel);
        grant_t g;
        int unsigned a;
        int idx;
        if (op == OP_ALLOC) begin
            a = chain_alloc(req);
            g.granted = a[17:0];
            g.ok = (a != 0);
            if (g.ok) live_blocks.push_back(a[17:0]);
        end else begin
            g.granted = '0;
            g.ok = chain_release(rel);
            if (g.ok) begin
                for (idx = 0; idx < live_blocks.size(); idx++)
                    if (live_blocks[idx] == rel) break;
                if (idx < live_blocks.size()) live_blocks.delete(idx);
            end
        end
        return g;
    endfunction

    task automatic send_beat(bit op, logic [23:0] req, logic [17:0] rel);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, rel, req};
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        grants_due.push_back(chain_step(op, req, rel));
        beats_sent++;
    endtask

    task automatic alloc_beat(logic [23:0] req);
        send_beat(OP_ALLOC, req, 18'($urandom));
    endtask

    task automatic release_beat(logic [17:0] rel);
        send_beat(OP_RELEASE, 24'($urandom), rel);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (grants_due.size() != 0) @(posedge aclk);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR beat %0d %s: got %0h want %0h", checked, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("first_fit_block_allocator: mismatch");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= 400;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        grant_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (grants_due.size() == 0) begin
                report_mismatch("unexpected beat", {m_tuser, m_tdata}, 0);
            end else begin
                want = grants_due.pop_front();
                if (m_tdata[17:0] !== want.granted)
                    report_mismatch("granted_address", m_tdata[17:0], want.granted);
                if (m_tdata[23:18] !== 6'b0)
                    report_mismatch("pad", m_tdata[23:18], 0);
                if (m_tuser[0] !== want.ok)
                    report_mismatch("success", m_tuser[0], want.ok);
            end
            checked++;
        end
    end

    task automatic test_corner_cases();
        alloc_beat(24'd0);
        alloc_beat(24'hFFFFFF);
        alloc_beat(24'(ARENA_BYTES - HEADER_BYTES + 1));
        release_beat(18'd0);
        release_beat(18'd8);
        release_beat(18'h3FFFF);
        alloc_beat(24'(ARENA_BYTES - HEADER_BYTES));
        alloc_beat(24'd1);
        release_beat(18'd16);
        release_beat(18'd16);
        alloc_beat(24'(ARENA_BYTES - HEADER_BYTES - 16));
        release_beat(18'd17);
        release_beat(18'd16);
    endtask

    task automatic test_split_merge();
        alloc_beat(24'd1);
        alloc_beat(24'd16);
        alloc_beat(24'd17);
        alloc_beat(24'd100);
        release_beat(18'd48);
        release_beat(18'd16);
        release_beat(18'd112);
        release_beat(18'd80);
        alloc_beat(24'd33);
        release_beat(18'd144);
        release_beat(18'd16);
    endtask

    task automatic test_random_mix(int count, int idle, int stall);
        int pick;
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 55)
                alloc_beat(24'($urandom_range(600, 1)));
            else if (pick < 60)
                alloc_beat(24'($urandom_range(40000, 1)));
            else if (pick < 92 && live_blocks.size() != 0)
                release_beat(live_blocks[$urandom_range(live_blocks.size() - 1)]);
            else if (pick < 96)
                alloc_beat(24'($urandom));
            else
                release_beat(18'($urandom));
        end
        drain();
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_seq++;
        repeat (12) alloc_beat(24'($urandom_range(200, 1)));
        drain();
        repeat (60) @(posedge aclk);
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_seq = 0;
        mismatches = 0;
        checked = 0;
        beats_sent = 0;
        chain_reset();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_corner_cases();
        test_split_merge();
        drain();
        test_random_mix(220, 0, 0);
        test_random_mix(200, 71, 0);
        test_backpressure();
        test_random_mix(200, 0, 71);
        test_random_mix(200, 36, 36);

        drain();
        repeat (100) @(posedge aclk);
        $display("covered %0d beats: corner sizes, splits, merges, bad releases, stalls",
                 beats_sent);
        $display("%0d results checked, %0d blocks still held", checked, live_blocks.size());
        if (mismatches == 0 && grants_due.size() == 0)
            $display("first_fit_block_allocator: match");
        else
            $display("first_fit_block_allocator: mismatch");
        $finish;
    end
endmodule
